// ===== rtl/core/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, constants and UTF-8 helpers for the XML entity unescaper.
// ----------------------------------------------------------------------------
package xeu_pkg;

	// Largest Unicode scalar value
	localparam logic [24:0] MAX_CODE_POINT = 25'h10FFFF;

	// Result status codes
	localparam logic [2:0] ST_DATA        = 3'd0;
	localparam logic [2:0] ST_UNTERMINATED = 3'd1;
	localparam logic [2:0] ST_BAD_HEX     = 3'd2;
	localparam logic [2:0] ST_BAD_DEC     = 3'd3;
	localparam logic [2:0] ST_RANGE       = 3'd4;
	localparam logic [2:0] ST_UNKNOWN     = 3'd5;

	// Queue depth between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Input transaction
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last_of_run;
		logic       last_of_string;
	} out_item_t;

	// Work handed from front to back
	typedef enum logic [1:0] {
		CMD_BYTE,   // emit one raw byte
		CMD_CP,     // emit a code point as UTF-8
		CMD_ERR     // emit one error result
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [20:0] value;   // raw byte in [7:0], or code point
		logic [2:0]  status;  // error code for CMD_ERR
		logic        eos;     // command came from the final byte
	} cmd_t;

	// Index of the last UTF-8 byte for a code point (length minus one)
	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		logic [1:0] r;
		if (cp < 21'h80)         r = 2'd0;
		else if (cp < 21'h800)   r = 2'd1;
		else if (cp < 21'h10000) r = 2'd2;
		else                     r = 2'd3;
		return r;
	endfunction

	// UTF-8 byte number idx of a code point
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] r;
		logic [1:0] last;
		logic [1:0] from_end;
		last     = utf8_last(cp);
		from_end = last - idx;
		if (last == 2'd0) begin
			r = cp[7:0];
		end else if (idx == 2'd0) begin
			unique case (last)
				2'd1:    r = {3'b110, cp[10:6]};
				2'd2:    r = {4'b1110, cp[15:12]};
				default: r = {5'b11110, cp[20:18]};
			endcase
		end else begin
			// continuation byte: six bits per position counted from the end
			unique case (from_end)
				2'd0:    r = {2'b10, cp[5:0]};
				2'd1:    r = {2'b10, cp[11:6]};
				default: r = {2'b10, cp[17:12]};
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/xeu_front.sv =====
// ----------------------------------------------------------------------------
// xeu_front
// Parses the byte stream: tracks entity bodies, accumulates numeric
// references and turns each input byte into at most one command.
// ----------------------------------------------------------------------------
module xeu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,      // input transaction accepted
	input  xeu_pkg::in_item_t item,
	output logic              push,
	output xeu_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		M_TEXT,
		M_ENTITY,
		M_DROP
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [2:0]       body_len_q, body_len_d;
	logic [3:0][7:0]  name_q, name_d;
	logic             numeric_q, numeric_d;
	logic             hex_q, hex_d;
	logic [20:0]      cp_q, cp_d;
	logic [2:0]       perr_q, perr_d;

	logic [7:0]  b;
	logic        eos;
	logic [3:0]  hex_digit;
	logic        hex_ok;
	logic        dec_ok;
	logic [24:0] hex_next;
	logic [24:0] dec_next;
	logic        is_lt, is_gt, is_amp, is_quot, is_apos;

	assign b   = item.in_byte;
	assign eos = item.end_of_string;

	// Digit decode
	always_comb begin
		hex_ok    = 1'b1;
		hex_digit = 4'd0;
		if (b >= 8'h30 && b <= 8'h39)      hex_digit = b[3:0];
		else if (b >= 8'h61 && b <= 8'h66) hex_digit = 4'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46) hex_digit = 4'(b - 8'h37);
		else                               hex_ok    = 1'b0;
	end

	assign dec_ok   = (b >= 8'h30) && (b <= 8'h39);
	assign hex_next = {cp_q, hex_digit};
	// cp * 10 + digit as two shifted adds
	assign dec_next = {1'b0, cp_q, 3'b000} + {3'b000, cp_q, 1'b0} + {21'd0, b[3:0]};

	// Named entities: lt gt amp quot apos
	assign is_lt   = body_len_q == 3'd2 && name_q[0] == 8'h6C && name_q[1] == 8'h74;
	assign is_gt   = body_len_q == 3'd2 && name_q[0] == 8'h67 && name_q[1] == 8'h74;
	assign is_amp  = body_len_q == 3'd3 && name_q[0] == 8'h61 && name_q[1] == 8'h6D
	                 && name_q[2] == 8'h70;
	assign is_quot = body_len_q == 3'd4 && name_q[0] == 8'h71 && name_q[1] == 8'h75
	                 && name_q[2] == 8'h6F && name_q[3] == 8'h74;
	assign is_apos = body_len_q == 3'd4 && name_q[0] == 8'h61 && name_q[1] == 8'h70
	                 && name_q[2] == 8'h6F && name_q[3] == 8'h73;

	// Next state and command
	always_comb begin
		mode_d     = mode_q;
		body_len_d = body_len_q;
		name_d     = name_q;
		numeric_d  = numeric_q;
		hex_d      = hex_q;
		cp_d       = cp_q;
		perr_d     = perr_q;
		push       = 1'b0;
		cmd.kind   = xeu_pkg::CMD_BYTE;
		cmd.value  = {13'd0, b};
		cmd.status = xeu_pkg::ST_DATA;
		cmd.eos    = eos;

		if (take) begin
			unique case (mode_q)
				M_DROP: begin
					if (eos) mode_d = M_TEXT;
				end
				M_ENTITY: begin
					if (b != 8'h3B) begin
						if (eos) begin
							// open entity at end of string
							push       = 1'b1;
							cmd.kind   = xeu_pkg::CMD_ERR;
							cmd.status = xeu_pkg::ST_UNTERMINATED;
							mode_d     = M_TEXT;
						end else begin
							// absorb one body byte
							if (body_len_q < 3'd4) name_d[body_len_q[1:0]] = b;
							if (body_len_q == 3'd0 && b == 8'h23) begin
								numeric_d = 1'b1;
							end else if (numeric_q && body_len_q == 3'd1 &&
							             (b == 8'h78 || b == 8'h58)) begin
								hex_d = 1'b1;
							end else if (numeric_q && hex_q) begin
								if (!hex_ok) begin
									if (perr_q == xeu_pkg::ST_DATA) perr_d = xeu_pkg::ST_BAD_HEX;
								end else if (perr_q == xeu_pkg::ST_DATA) begin
									if (hex_next > xeu_pkg::MAX_CODE_POINT)
										perr_d = xeu_pkg::ST_RANGE;
									else
										cp_d = hex_next[20:0];
								end
							end else if (numeric_q) begin
								if (!dec_ok) begin
									if (perr_q == xeu_pkg::ST_DATA) perr_d = xeu_pkg::ST_BAD_DEC;
								end else if (perr_q == xeu_pkg::ST_DATA) begin
									if (dec_next > xeu_pkg::MAX_CODE_POINT)
										perr_d = xeu_pkg::ST_RANGE;
									else
										cp_d = dec_next[20:0];
								end
							end
							if (body_len_q != 3'd7) body_len_d = body_len_q + 3'd1;
						end
					end else begin
						// closing ';'
						push   = 1'b1;
						mode_d = M_TEXT;
						if (perr_q != xeu_pkg::ST_DATA) begin
							cmd.kind   = xeu_pkg::CMD_ERR;
							cmd.status = perr_q;
							mode_d     = eos ? M_TEXT : M_DROP;
						end else if (numeric_q) begin
							cmd.kind  = xeu_pkg::CMD_CP;
							cmd.value = cp_q;
						end else if (is_lt)   cmd.value = 21'h3C;
						else if (is_gt)       cmd.value = 21'h3E;
						else if (is_amp)      cmd.value = 21'h26;
						else if (is_quot)     cmd.value = 21'h22;
						else if (is_apos)     cmd.value = 21'h27;
						else begin
							cmd.kind   = xeu_pkg::CMD_ERR;
							cmd.status = xeu_pkg::ST_UNKNOWN;
							mode_d     = eos ? M_TEXT : M_DROP;
						end
					end
				end
				default: begin
					if (b == 8'h26) begin
						if (eos) begin
							push       = 1'b1;
							cmd.kind   = xeu_pkg::CMD_ERR;
							cmd.status = xeu_pkg::ST_UNTERMINATED;
						end else begin
							mode_d = M_ENTITY;
						end
					end else begin
						push = 1'b1;
					end
				end
			endcase

			// every path that leaves the entity or opens a new one clears the body
			if (mode_d != M_ENTITY || mode_q != M_ENTITY) begin
				body_len_d = 3'd0;
				name_d     = '0;
				numeric_d  = 1'b0;
				hex_d      = 1'b0;
				cp_d       = '0;
				perr_d     = xeu_pkg::ST_DATA;
			end
		end

		if (cmd.kind == xeu_pkg::CMD_ERR) cmd.value = '0;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_TEXT;
			body_len_q <= 3'd0;
			name_q     <= '0;
			numeric_q  <= 1'b0;
			hex_q      <= 1'b0;
			cp_q       <= '0;
			perr_q     <= xeu_pkg::ST_DATA;
		end else begin
			mode_q     <= mode_d;
			body_len_q <= body_len_d;
			name_q     <= name_d;
			numeric_q  <= numeric_d;
			hex_q      <= hex_d;
			cp_q       <= cp_d;
			perr_q     <= perr_d;
		end
	end

endmodule

// ===== rtl/core/xeu_queue.sv =====
// ----------------------------------------------------------------------------
// xeu_queue
// Small command FIFO between the parsing front and the emitting back.
// ----------------------------------------------------------------------------
module xeu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xeu_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output xeu_pkg::cmd_t head
);

	xeu_pkg::cmd_t                  store_q [xeu_pkg::QUEUE_DEPTH];
	logic [xeu_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [xeu_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [xeu_pkg::QUEUE_AW:0]     count_q;

	assign full       = count_q == (xeu_pkg::QUEUE_AW+1)'(xeu_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push && !full) store_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)      wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && head_valid)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push && !full, pop && head_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/xeu_back.sv =====
// ----------------------------------------------------------------------------
// xeu_back
// Expands each command into its result transactions, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module xeu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  xeu_pkg::cmd_t      head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output xeu_pkg::out_item_t result
);

	logic               out_valid_q;
	xeu_pkg::out_item_t out_q;
	logic [1:0]         idx_q;
	logic [1:0]         last_idx;
	logic               advance;
	xeu_pkg::out_item_t item;

	// Build the next result from the queue head
	always_comb begin
		last_idx = (head.kind == xeu_pkg::CMD_CP) ? xeu_pkg::utf8_last(head.value) : 2'd0;
		advance  = head_valid && (!out_valid_q || result_ready);
		pop      = advance && (idx_q == last_idx);
		unique case (head.kind)
			xeu_pkg::CMD_CP: begin
				item.out_byte       = xeu_pkg::utf8_byte(head.value, idx_q);
				item.status         = xeu_pkg::ST_DATA;
				item.last_of_run    = idx_q == last_idx;
				item.last_of_string = (idx_q == last_idx) && head.eos;
			end
			xeu_pkg::CMD_ERR: begin
				item.out_byte       = 8'd0;
				item.status         = head.status;
				item.last_of_run    = 1'b1;
				item.last_of_string = 1'b1;
			end
			default: begin
				item.out_byte       = head.value[7:0];
				item.status         = xeu_pkg::ST_DATA;
				item.last_of_run    = 1'b1;
				item.last_of_string = head.eos;
			end
		endcase
	end

	// Output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= pop ? 2'd0 : idx_q + 2'd1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) out_q <= item;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/core/xml_entity_unescape.sv =====
// ----------------------------------------------------------------------------
// xml_entity_unescape
// Streaming XML entity decoder: plain bytes pass, entities become UTF-8.
// ----------------------------------------------------------------------------
// One input byte is accepted per clock whenever the four-entry command queue
// has room; the parser front decides in that same cycle what the byte causes
// (nothing, a raw byte, a code point or an error) and queues it. The back end
// drains the queue at one result per clock unless the output stalls, so a
// numeric reference yields one to four results, set by its UTF-8 length. A
// byte's first result goes through the queue and the output register. Errors
// produce a single result with both last flags set, after which input is dropped
// up to the end of the string. There is no configuration and no start-up sweep.
module xml_entity_unescape (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  xeu_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output xeu_pkg::out_item_t result
);

	logic          push;
	xeu_pkg::cmd_t cmd;
	logic          full;
	logic          pop;
	logic          head_valid;
	xeu_pkg::cmd_t head;

	assign item_ready = !full;

	xeu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (item_valid && item_ready),
		.item   (item),
		.push   (push),
		.cmd    (cmd)
	);

	xeu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	xeu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
